[rtl/racd_pkg.sv]
// ----------------------------------------------------------------------------
// racd_pkg
// shared types and constants of the rotation aligned cosine distance block
// ----------------------------------------------------------------------------
package racd_pkg;

  localparam int VALUE_W     = 16;
  localparam int DIST_W      = 17;
  localparam int SHIFT_W     = 6;
  localparam int FRAC_BITS   = 16;
  localparam int SECT_REG_W  = 7;
  localparam int RING_REG_W  = 6;

  localparam logic [DIST_W-1:0]     ONE_Q16       = 17'd65536;
  localparam logic [SECT_REG_W-1:0] SECTORS_RESET = 7'd60;
  localparam logic [RING_REG_W-1:0] RINGS_RESET   = 6'd20;

  localparam logic REG_SECTORS = 1'b0;
  localparam logic REG_RINGS   = 1'b1;

  typedef struct packed {
    logic                zero_norm_seen;
    logic [SHIFT_W-1:0]  best_shift;
    logic [DIST_W-1:0]   min_distance;
  } racd_result_t;

endpackage

[rtl/racd_ram.sv]
// ----------------------------------------------------------------------------
// racd_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module racd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/racd_sqrt.sv]
// ----------------------------------------------------------------------------
// racd_sqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module racd_sqrt #(
  parameter int ROOT_W = 19
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   x,
  output logic                  done,
  output logic [ROOT_W-1:0]     root
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] rad;
  logic [ROOT_W+1:0]   rem;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic [ROOT_W+3:0]   rem_s;
  logic [ROOT_W+3:0]   trial;
  logic                ge;

  assign rem_s = {rem, rad[2*ROOT_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = rem_s >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= x;
        rem  <= '0;
        root <= '0;
        cnt  <= CNT_W'(ROOT_W);
        busy <= 1'b1;
      end else if (busy) begin
        rad  <= rad << 2;
        rem  <= ge ? (ROOT_W+2)'(rem_s - trial) : (ROOT_W+2)'(rem_s);
        root <= {root[ROOT_W-2:0], ge};
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/racd_div.sv]
// ----------------------------------------------------------------------------
// racd_div
// iterative restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module racd_div #(
  parameter int REM_W = 39,
  parameter int QUO_W = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [REM_W-1:0]             r0,
  input  logic [QUO_W-1:0]             dividend,
  input  logic [REM_W-1:0]             den,
  input  logic [$clog2(QUO_W+1)-1:0]   steps,
  output logic                         done,
  output logic [QUO_W-1:0]             quotient
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] den_q;
  logic [QUO_W-1:0] dvd;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [REM_W-1:0] rs;
  logic             ge;

  assign rs = {rem[REM_W-2:0], dvd[QUO_W-1]};
  assign ge = rs >= den_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= r0;
        den_q    <= den;
        dvd      <= dividend;
        quotient <= '0;
        cnt      <= steps;
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= ge ? rs - den_q : rs;
        dvd      <= dvd << 1;
        quotient <= {quotient[QUO_W-2:0], ge};
        cnt      <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/racd_search.sv]
// ----------------------------------------------------------------------------
// racd_search
// column norms, then per shift cosine mean and running minimum
// ----------------------------------------------------------------------------
module racd_search #(
  parameter int MAX_SECTORS = 64,
  parameter int MAX_RINGS   = 32
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          start,
  input  logic [$clog2(MAX_SECTORS+1)-1:0]              ns,
  input  logic [$clog2(MAX_RINGS+1)-1:0]                nr,
  input  logic [$clog2(MAX_SECTORS*MAX_RINGS):0]        total,
  output logic [$clog2(MAX_SECTORS*MAX_RINGS)-1:0]      rd_addr_a,
  output logic [$clog2(MAX_SECTORS*MAX_RINGS)-1:0]      rd_addr_b,
  input  logic [racd_pkg::VALUE_W-1:0]                  rd_data_a,
  input  logic [racd_pkg::VALUE_W-1:0]                  rd_data_b,
  output logic                                          busy,
  output logic                                          res_valid,
  input  logic                                          res_ready,
  output racd_pkg::racd_result_t                        result
);
  import racd_pkg::*;

  localparam int AW     = $clog2(MAX_SECTORS * MAX_RINGS);
  localparam int SEC_W  = $clog2(MAX_SECTORS);
  localparam int SCNT_W = $clog2(MAX_SECTORS + 1);
  localparam int RCNT_W = $clog2(MAX_RINGS + 1);
  localparam int ACC_W  = 2 * VALUE_W + $clog2(MAX_RINGS + 1);
  localparam int ROOT_W = (ACC_W + 1) / 2;
  localparam int DEN_W  = 2 * ROOT_W;
  localparam int REM_W  = DEN_W + 1;
  localparam int SUM_W  = DIST_W + SCNT_W;
  localparam int DCNT_W = $clog2(SUM_W + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_NISSUE, S_NDRAIN, S_NWAIT, S_DISSUE, S_DDRAIN, S_DEN,
    S_FRAC, S_FWAIT, S_MEAN, S_MWAIT, S_DONE
  } state_t;

  state_t state;

  logic [RCNT_W-1:0]  ring;
  logic [SEC_W-1:0]   col, ca, ca0, shift;
  logic [AW-1:0]      addr_a, addr_b, base_a, base_b, base_a0;
  logic               v1, v2, dot_phase;
  logic [2*VALUE_W-1:0] prod_a, prod_b;
  logic [ACC_W-1:0]   acc_a, acc_b;
  logic [DEN_W-1:0]   den;
  logic [SUM_W-1:0]   sum;
  logic [DIST_W-1:0]  best;
  logic [SEC_W-1:0]   best_idx;
  logic               zero_seen;

  logic               issuing, ring_last, col_last, shift_last;
  logic               sq_start, sq_done_a, sq_done_b;
  logic [ROOT_W-1:0]  root_a, root_b, norm_a, norm_b;
  logic               norm_we;
  logic               div_start, div_done;
  logic [REM_W-1:0]   div_r0, div_den;
  logic [SUM_W-1:0]   div_dvd, quo;
  logic [DCNT_W-1:0]  div_steps;
  logic               cos_ge, col_end;
  logic [DIST_W-1:0]  cos_val, shift_dist;
  logic [AW-1:0]      nr_a;
  logic               zero_col;

  assign nr_a       = AW'(nr);
  assign issuing    = (state == S_NISSUE) || (state == S_DISSUE);
  assign ring_last  = ring == nr - RCNT_W'(1);
  assign col_last   = SCNT_W'(col) == ns - SCNT_W'(1);
  assign shift_last = SCNT_W'(shift) == ns - SCNT_W'(1);
  assign rd_addr_a  = addr_a;
  assign rd_addr_b  = addr_b;

  assign sq_start = (state == S_NDRAIN) && !v1 && !v2;
  assign norm_we  = (state == S_NWAIT) && sq_done_a;
  assign zero_col = (root_a == '0) || (root_b == '0);

  racd_ram #(.WIDTH(ROOT_W), .DEPTH(MAX_SECTORS)) u_norm_a (
    .clk(clk), .we(norm_we), .waddr(col), .wdata(root_a), .raddr(ca), .rdata(norm_a)
  );
  racd_ram #(.WIDTH(ROOT_W), .DEPTH(MAX_SECTORS)) u_norm_b (
    .clk(clk), .we(norm_we), .waddr(col), .wdata(root_b), .raddr(col), .rdata(norm_b)
  );

  racd_sqrt #(.ROOT_W(ROOT_W)) u_sqrt_a (
    .clk(clk), .rst(rst), .start(sq_start), .x(DEN_W'(acc_a)),
    .done(sq_done_a), .root(root_a)
  );
  racd_sqrt #(.ROOT_W(ROOT_W)) u_sqrt_b (
    .clk(clk), .rst(rst), .start(sq_start), .x(DEN_W'(acc_b)),
    .done(sq_done_b), .root(root_b)
  );

  assign cos_ge = DEN_W'(acc_a) >= den;

  always_comb begin
    div_start = 1'b0;
    div_r0    = REM_W'(acc_a);
    div_dvd   = '0;
    div_den   = REM_W'(den);
    div_steps = DCNT_W'(FRAC_BITS);
    if (state == S_FRAC) begin
      div_start = !cos_ge;
    end else if (state == S_MEAN) begin
      div_start = 1'b1;
      div_r0    = '0;
      div_dvd   = sum;
      div_den   = REM_W'(ns);
      div_steps = DCNT_W'(SUM_W);
    end
  end

  racd_div #(.REM_W(REM_W), .QUO_W(SUM_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .r0(div_r0), .dividend(div_dvd),
    .den(div_den), .steps(div_steps), .done(div_done), .quotient(quo)
  );

  assign col_end    = ((state == S_FRAC) && cos_ge) || ((state == S_FWAIT) && div_done);
  assign cos_val    = (state == S_FRAC) ? ONE_Q16 : DIST_W'(quo[FRAC_BITS-1:0]);
  assign shift_dist = ONE_Q16 - quo[DIST_W-1:0];

  assign busy      = state != S_IDLE;
  assign res_valid = state == S_DONE;
  assign result    = '{zero_norm_seen: zero_seen,
                       best_shift:     SHIFT_W'(best_idx),
                       min_distance:   best};

  // multiply-accumulate pipeline behind the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issuing;
      v2 <= v1;
    end
    if (v1) begin
      prod_a <= dot_phase ? rd_data_a * rd_data_b : rd_data_a * rd_data_a;
      prod_b <= rd_data_b * rd_data_b;
    end
    if (state == S_IDLE || norm_we || col_end) begin
      acc_a <= '0;
      acc_b <= '0;
    end else if (v2) begin
      acc_a <= acc_a + ACC_W'(prod_a);
      acc_b <= acc_b + ACC_W'(prod_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dot_phase <= 1'b0;
      zero_seen <= 1'b0;
      best      <= ONE_Q16;
      best_idx  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            col       <= '0;
            ring      <= '0;
            addr_a    <= '0;
            addr_b    <= '0;
            dot_phase <= 1'b0;
            zero_seen <= 1'b0;
            state     <= S_NISSUE;
          end
        end
        S_NISSUE, S_DISSUE: begin
          addr_a <= addr_a + AW'(1);
          addr_b <= addr_b + AW'(1);
          ring   <= ring + RCNT_W'(1);
          if (ring_last) begin
            state <= (state == S_NISSUE) ? S_NDRAIN : S_DDRAIN;
          end
        end
        S_NDRAIN: begin
          if (!v1 && !v2) begin
            state <= S_NWAIT;
          end
        end
        S_NWAIT: begin
          if (sq_done_a) begin
            ring <= '0;
            if (!col_last) begin
              zero_seen <= zero_seen | zero_col;
              col       <= col + SEC_W'(1);
              state     <= S_NISSUE;
            end else if (zero_seen || zero_col) begin
              zero_seen <= 1'b1;
              best      <= ONE_Q16;
              best_idx  <= '0;
              state     <= S_DONE;
            end else begin
              dot_phase <= 1'b1;
              best      <= ONE_Q16;
              best_idx  <= '0;
              shift     <= '0;
              ca0       <= '0;
              base_a0   <= '0;
              ca        <= '0;
              col       <= '0;
              base_a    <= '0;
              base_b    <= '0;
              addr_a    <= '0;
              addr_b    <= '0;
              sum       <= '0;
              state     <= S_DISSUE;
            end
          end
        end
        S_DDRAIN: begin
          if (!v1 && !v2) begin
            state <= S_DEN;
          end
        end
        S_DEN: begin
          den   <= norm_a * norm_b;
          state <= S_FRAC;
        end
        S_FRAC: begin
          if (!cos_ge) begin
            state <= S_FWAIT;
          end
        end
        S_FWAIT: begin
        end
        S_MEAN: begin
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (div_done) begin
            if (shift_dist < best) begin
              best     <= shift_dist;
              best_idx <= shift;
            end
            if (shift_last) begin
              state <= S_DONE;
            end else begin
              shift  <= shift + SEC_W'(1);
              col    <= '0;
              base_b <= '0;
              addr_b <= '0;
              sum    <= '0;
              ring   <= '0;
              if (ca0 == '0) begin
                ca0     <= SEC_W'(ns - SCNT_W'(1));
                ca      <= SEC_W'(ns - SCNT_W'(1));
                base_a0 <= AW'(total - (AW+1)'(nr));
                base_a  <= AW'(total - (AW+1)'(nr));
                addr_a  <= AW'(total - (AW+1)'(nr));
              end else begin
                ca0     <= ca0 - SEC_W'(1);
                ca      <= ca0 - SEC_W'(1);
                base_a0 <= base_a0 - nr_a;
                base_a  <= base_a0 - nr_a;
                addr_a  <= base_a0 - nr_a;
              end
              state <= S_DISSUE;
            end
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (col_end) begin
        sum  <= sum + SUM_W'(cos_val);
        ring <= '0;
        if (col_last) begin
          state <= S_MEAN;
        end else begin
          col    <= col + SEC_W'(1);
          base_b <= base_b + nr_a;
          addr_b <= base_b + nr_a;
          if (SCNT_W'(ca) == ns - SCNT_W'(1)) begin
            ca     <= '0;
            base_a <= '0;
            addr_a <= '0;
          end else begin
            ca     <= ca + SEC_W'(1);
            base_a <= base_a + nr_a;
            addr_a <= base_a + nr_a;
          end
          state <= S_DISSUE;
        end
      end
    end
  end

endmodule

[rtl/rotation_aligned_cosine_distance.sv]
// ----------------------------------------------------------------------------
// rotation_aligned_cosine_distance
// loads two ring-by-sector descriptors, then searches the column shift with
// the smallest mean cosine distance
// operation: S*R transactions load at one per cycle while the search is idle, then the
//   search runs on the shared multiply-accumulate path, the iterative square root
//   and the serial divider
// throughput: one result per load of S*R items; input stalls during the search
// reset: registers return to 60 sectors and 20 rings, load count to zero
// ----------------------------------------------------------------------------
module rotation_aligned_cosine_distance #(
  parameter int MAX_SECTORS = 64,
  parameter int MAX_RINGS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value_a, value_b
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // min_distance, best_shift, zero_norm_seen
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import racd_pkg::*;

  localparam int AW     = $clog2(MAX_SECTORS * MAX_RINGS);
  localparam int SCNT_W = $clog2(MAX_SECTORS + 1);
  localparam int RCNT_W = $clog2(MAX_RINGS + 1);

  logic [SECT_REG_W-1:0] sectors_in_use;
  logic [RING_REG_W-1:0] rings_in_use;
  logic [SCNT_W-1:0]     ns;
  logic [RCNT_W-1:0]     nr;
  logic [AW:0]           total, load_count;
  logic                  cfg_wr, in_acc, last_item;
  logic [AW-1:0]         rd_addr_a, rd_addr_b;
  logic [VALUE_W-1:0]    rd_data_a, rd_data_b;
  logic                  busy, res_valid, res_ready;
  racd_result_t          result;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_RINGS) ? 32'(rings_in_use) : 32'(sectors_in_use);

  always_comb begin
    if (sectors_in_use == '0) begin
      ns = SCNT_W'(1);
    end else if (32'(sectors_in_use) > MAX_SECTORS) begin
      ns = SCNT_W'(MAX_SECTORS);
    end else begin
      ns = SCNT_W'(sectors_in_use);
    end
    if (rings_in_use == '0) begin
      nr = RCNT_W'(1);
    end else if (32'(rings_in_use) > MAX_RINGS) begin
      nr = RCNT_W'(MAX_RINGS);
    end else begin
      nr = RCNT_W'(rings_in_use);
    end
  end

  assign total     = (AW+1)'(ns * nr);
  assign s_tready  = !busy;
  assign in_acc    = s_tvalid && s_tready;
  assign last_item = in_acc && (load_count + (AW+1)'(1) == total);
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sectors_in_use <= SECTORS_RESET;
      rings_in_use   <= RINGS_RESET;
      load_count     <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        load_count <= '0;
        if (paddr[2] == REG_SECTORS) begin
          sectors_in_use <= pwdata[SECT_REG_W-1:0];
        end else begin
          rings_in_use <= pwdata[RING_REG_W-1:0];
        end
      end else if (last_item) begin
        load_count <= '0;
      end else if (in_acc) begin
        load_count <= load_count + (AW+1)'(1);
      end
      if (res_valid && res_ready) begin
        m_tvalid <= 1'b1;
        m_tdata  <= result;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  racd_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_SECTORS * MAX_RINGS)) u_store_a (
    .clk(clk), .we(in_acc), .waddr(load_count[AW-1:0]), .wdata(s_tdata[15:0]),
    .raddr(rd_addr_a), .rdata(rd_data_a)
  );
  racd_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_SECTORS * MAX_RINGS)) u_store_b (
    .clk(clk), .we(in_acc), .waddr(load_count[AW-1:0]), .wdata(s_tdata[31:16]),
    .raddr(rd_addr_b), .rdata(rd_data_b)
  );

  racd_search #(.MAX_SECTORS(MAX_SECTORS), .MAX_RINGS(MAX_RINGS)) u_search (
    .clk(clk), .rst(rst), .start(last_item), .ns(ns), .nr(nr), .total(total),
    .rd_addr_a(rd_addr_a), .rd_addr_b(rd_addr_b),
    .rd_data_a(rd_data_a), .rd_data_b(rd_data_b),
    .busy(busy), .res_valid(res_valid), .res_ready(res_ready), .result(result)
  );

endmodule

[test/rotation_aligned_cosine_distance_test.sv]
// ----------------------------------------------------------------------------
// rotation_aligned_cosine_distance_test
// streams descriptor pairs into the block under several sector and ring
// settings, predicts the best rotation, distance and zero-norm flag of each
// completed load, and compares every result transaction in order
// ----------------------------------------------------------------------------
module rotation_aligned_cosine_distance_test;
  timeunit 1ns;
  timeprecision 1ps;
  import racd_pkg::*;

  localparam int MAXS = 64;
  localparam int MAXR = 32;

  localparam int KIND_RANDOM   = 0;
  localparam int KIND_ROTATED  = 1;
  localparam int KIND_ZERO_COL = 2;
  localparam int KIND_TINY     = 3;
  localparam int KIND_FULL     = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rotation_aligned_cosine_distance u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [SECT_REG_W-1:0] model_sectors = SECTORS_RESET;
  logic [RING_REG_W-1:0] model_rings = RINGS_RESET;
  logic [VALUE_W-1:0]    desc_a [MAXS*MAXR];
  logic [VALUE_W-1:0]    desc_b [MAXS*MAXR];
  int                    loaded = 0;
  racd_result_t          pending_results [$];

  int  errors = 0;
  bit  steady = 1'b0;
  int  hold_off = 0;
  logic [VALUE_W-1:0] gen_a [MAXS*MAXR];
  logic [VALUE_W-1:0] gen_b [MAXS*MAXR];

  function automatic int eff_sectors();
    if (model_sectors < 1) return 1;
    if (model_sectors > MAXS) return MAXS;
    return int'(model_sectors);
  endfunction

  function automatic int eff_rings();
    if (model_rings < 1) return 1;
    if (model_rings > MAXR) return MAXR;
    return int'(model_rings);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'd4294967296;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= x) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic racd_result_t best_rotation();
    racd_result_t    res;
    int              ns, nr, ca;
    longint unsigned na [MAXS];
    longint unsigned nb [MAXS];
    longint unsigned sa, sb, dot, den, sum, cosv, dist_val;
    bit              bad;
    ns = eff_sectors();
    nr = eff_rings();
    res.min_distance = ONE_Q16;
    res.best_shift = '0;
    res.zero_norm_seen = 1'b0;
    for (int s = 0; s < ns; s++) begin
      sa = 0;
      sb = 0;
      for (int r = 0; r < nr; r++) begin
        sa += longint'(desc_a[s*nr+r]) * desc_a[s*nr+r];
        sb += longint'(desc_b[s*nr+r]) * desc_b[s*nr+r];
      end
      na[s] = int_sqrt(sa);
      nb[s] = int_sqrt(sb);
      if (na[s] == 0 || nb[s] == 0) res.zero_norm_seen = 1'b1;
    end
    for (int k = 0; k < ns; k++) begin
      sum = 0;
      bad = 1'b0;
      for (int i = 0; i < ns; i++) begin
        ca = (i + ns - k) % ns;
        den = na[ca] * nb[i];
        if (den == 0) begin
          bad = 1'b1;
        end else begin
          dot = 0;
          for (int r = 0; r < nr; r++)
            dot += longint'(desc_a[ca*nr+r]) * desc_b[i*nr+r];
          if (dot >= den) cosv = 65536;
          else cosv = (dot << 16) / den;
          sum += cosv;
        end
      end
      if (!bad) begin
        dist_val = 65536 - sum / ns;
        if (dist_val < res.min_distance) begin
          res.min_distance = dist_val[DIST_W-1:0];
          res.best_shift = k[SHIFT_W-1:0];
        end
      end
    end
    return res;
  endfunction

  // input capture, prediction and result check
  always @(posedge clk) begin
    racd_result_t got, want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        if (loaded >= eff_sectors() * eff_rings()) loaded = 0;
        desc_a[loaded] = s_tdata[15:0];
        desc_b[loaded] = s_tdata[31:16];
        loaded++;
        if (loaded == eff_sectors() * eff_rings()) begin
          loaded = 0;
          pending_results = {pending_results, best_rotation()};
        end
      end
      if (m_tvalid && m_tready) begin
        got = racd_result_t'(m_tdata);
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_tdata);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.min_distance !== want.min_distance) begin
            $display("%0t: min_distance expected %0d actual %0d",
                     $time, want.min_distance, got.min_distance);
            errors++;
          end
          if (got.best_shift !== want.best_shift) begin
            $display("%0t: best_shift expected %0d actual %0d",
                     $time, want.best_shift, got.best_shift);
            errors++;
          end
          if (got.zero_norm_seen !== want.zero_norm_seen) begin
            $display("%0t: zero_norm_seen expected %0d actual %0d",
                     $time, want.zero_norm_seen, got.zero_norm_seen);
            errors++;
          end
        end
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off > 0) begin
      m_tready <= 1'b0;
      hold_off--;
    end else if (steady) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 38);
    end
  end

  task automatic send_pair(input logic [15:0] a, input logic [15:0] b);
    if (!steady && $urandom_range(99) < 38) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {b, a};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic stop_sending();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic reg_write(input logic addr_sel, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr_sel == REG_RINGS ? 3'd4 : 3'd0;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr_sel == REG_SECTORS) model_sectors = value[SECT_REG_W-1:0];
    else model_rings = value[RING_REG_W-1:0];
    loaded = 0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_shape(input int sect, input int rings);
    drain();
    reg_write(REG_SECTORS, sect);
    reg_write(REG_RINGS, rings);
  endtask

  task automatic make_load(input int kind);
    int ns, nr, rot, zc;
    ns = eff_sectors();
    nr = eff_rings();
    rot = $urandom_range(ns - 1);
    zc = $urandom_range(ns - 1);
    for (int n = 0; n < ns * nr; n++) begin
      case (kind)
        KIND_TINY: begin
          gen_a[n] = 16'($urandom_range(3));
          gen_b[n] = 16'($urandom_range(3));
        end
        KIND_FULL: begin
          gen_a[n] = $urandom_range(1) ? 16'hffff : 16'($urandom_range(65535, 65000));
          gen_b[n] = $urandom_range(1) ? 16'hffff : 16'($urandom);
        end
        default: begin
          gen_a[n] = 16'($urandom);
          gen_b[n] = 16'($urandom);
        end
      endcase
    end
    if (kind == KIND_ROTATED) begin
      for (int i = 0; i < ns; i++)
        for (int r = 0; r < nr; r++)
          gen_b[i*nr+r] = gen_a[((i + ns - rot) % ns)*nr+r] ^ 16'($urandom_range(1));
    end
    if (kind == KIND_ZERO_COL) begin
      for (int r = 0; r < nr; r++) begin
        if ($urandom_range(1)) gen_a[zc*nr+r] = '0;
        else gen_b[zc*nr+r] = '0;
      end
      for (int r = 0; r < nr; r++) gen_a[zc*nr+r] = '0;
    end
  endtask

  task automatic send_load(input int count);
    for (int n = 0; n < count; n++) send_pair(gen_a[n], gen_b[n]);
  endtask

  task automatic test_directed();
    set_shape(1, 1);
    send_pair(16'h0000, 16'h0000);
    send_pair(16'hffff, 16'hffff);
    send_pair(16'hffff, 16'h0001);
    send_pair(16'h0001, 16'h0000);
    set_shape(2, 2);
    send_pair(1, 1); send_pair(1, 1);
    send_pair(0, 0); send_pair(0, 0);
    send_pair(16'hffff, 0); send_pair(0, 16'hffff);
    send_pair(0, 16'hffff); send_pair(16'hffff, 0);
    set_shape(3, 1);
    send_pair(1, 3); send_pair(2, 1); send_pair(3, 2);
    drain();
  endtask

  task automatic test_register_extremes();
    send_pair(16'h1234, 16'h4321);
    send_pair(16'h5555, 16'haaaa);
    set_shape(127, 1);
    make_load(KIND_RANDOM);
    send_load(eff_sectors() * eff_rings());
    set_shape(0, 0);
    send_pair(16'h0100, 16'h0080);
    set_shape(1, 63);
    make_load(KIND_ROTATED);
    send_load(eff_sectors() * eff_rings());
    set_shape(1, 32);
    make_load(KIND_ZERO_COL);
    send_load(eff_sectors() * eff_rings());
    set_shape(64, 1);
    make_load(KIND_ROTATED);
    send_load(eff_sectors() * eff_rings());
    drain();
  endtask

  task automatic test_backpressure();
    set_shape(2, 1);
    hold_off = 3000;
    for (int l = 0; l < 3; l++) begin
      make_load(KIND_RANDOM);
      send_load(2);
    end
    drain();
  endtask

  task automatic test_random();
    int sent, count, kind;
    sent = 0;
    while (sent < 1220) begin
      set_shape($urandom_range(6, 1), $urandom_range(4, 1));
      steady = (sent > 500 && sent < 700);
      for (int l = 0; l < $urandom_range(4, 1); l++) begin
        kind = $urandom_range(9);
        make_load(kind > KIND_FULL ? KIND_RANDOM : kind);
        count = eff_sectors() * eff_rings();
        if ($urandom_range(99) < 10) begin
          count = $urandom_range(count - 1);
          send_load(count);
          sent += count;
          break;
        end
        send_load(count);
        sent += count;
      end
    end
    steady = 1'b0;
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

[sim.f]
rtl/racd_pkg.sv
rtl/racd_ram.sv
rtl/racd_sqrt.sv
rtl/racd_div.sv
rtl/racd_search.sv
rtl/rotation_aligned_cosine_distance.sv
test/rotation_aligned_cosine_distance_test.sv
